### rtl/acdi_pkg.sv
package acdi_pkg;

  // Axis count and fixed-point defaults
  localparam int MaxAxes     = 3;
  localparam int NumAxesDef  = 3;
  localparam int FracBitsDef = 16;

  // Field widths
  localparam int AccW   = 32;
  localparam int GainW  = 24;
  localparam int StepW  = 16;
  localparam int StateW = 48;

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] RegBiasX = 3'd0;
  localparam logic [CfgIdxW-1:0] RegBiasY = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBiasZ = 3'd2;
  localparam logic [CfgIdxW-1:0] RegGainX = 3'd3;
  localparam logic [CfgIdxW-1:0] RegGainY = 3'd4;
  localparam logic [CfgIdxW-1:0] RegGainZ = 3'd5;
  localparam logic [CfgIdxW-1:0] RegStep  = 3'd6;

  localparam logic [AccW-1:0]  BiasReset = '0;
  localparam logic [GainW-1:0] GainReset = 24'd65536;
  localparam logic [StepW-1:0] StepReset = 16'd655;

  // Datapath step commands issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_GAIN,
    OP_CORR,
    OP_MUL_CORR,
    OP_VEL,
    OP_MUL_VLO,
    OP_MUL_VHI,
    OP_POS
  } op_e;

endpackage

### rtl/acdi_cfg.sv
module acdi_cfg (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               cfg_we_i,
  input  logic [acdi_pkg::CfgIdxW-1:0]                       cfg_idx_i,
  input  logic [acdi_pkg::CfgDataW-1:0]                      cfg_data_i,
  output logic [acdi_pkg::MaxAxes-1:0][acdi_pkg::AccW-1:0]   bias_o,
  output logic [acdi_pkg::MaxAxes-1:0][acdi_pkg::GainW-1:0]  gain_o,
  output logic [acdi_pkg::StepW-1:0]                         step_o
);

  logic [acdi_pkg::MaxAxes-1:0][acdi_pkg::AccW-1:0]  bias_q;
  logic [acdi_pkg::MaxAxes-1:0][acdi_pkg::GainW-1:0] gain_q;
  logic [acdi_pkg::StepW-1:0]                        step_q;

  // Decode register writes; drop writes to unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q <= {acdi_pkg::MaxAxes{acdi_pkg::BiasReset}};
      gain_q <= {acdi_pkg::MaxAxes{acdi_pkg::GainReset}};
      step_q <= acdi_pkg::StepReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        acdi_pkg::RegBiasX: bias_q[0] <= cfg_data_i[acdi_pkg::AccW-1:0];
        acdi_pkg::RegBiasY: bias_q[1] <= cfg_data_i[acdi_pkg::AccW-1:0];
        acdi_pkg::RegBiasZ: bias_q[2] <= cfg_data_i[acdi_pkg::AccW-1:0];
        acdi_pkg::RegGainX: gain_q[0] <= cfg_data_i[acdi_pkg::GainW-1:0];
        acdi_pkg::RegGainY: gain_q[1] <= cfg_data_i[acdi_pkg::GainW-1:0];
        acdi_pkg::RegGainZ: gain_q[2] <= cfg_data_i[acdi_pkg::GainW-1:0];
        acdi_pkg::RegStep:  step_q    <= cfg_data_i[acdi_pkg::StepW-1:0];
        default: ;
      endcase
    end
  end

  assign bias_o = bias_q;
  assign gain_o = gain_q;
  assign step_o = step_q;

endmodule

### rtl/acdi_dp.sv
module acdi_dp #(
  parameter int NUM_AXES  = acdi_pkg::NumAxesDef,
  parameter int FRAC_BITS = acdi_pkg::FracBitsDef
) (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  acdi_pkg::op_e                                       op_i,
  input  logic [acdi_pkg::MaxAxes-1:0][acdi_pkg::AccW-1:0]    accel_i,
  input  logic [acdi_pkg::MaxAxes-1:0][acdi_pkg::AccW-1:0]    bias_i,
  input  logic [acdi_pkg::MaxAxes-1:0][acdi_pkg::GainW-1:0]   gain_i,
  input  logic [acdi_pkg::StepW-1:0]                          step_i,
  output logic [acdi_pkg::MaxAxes-1:0][acdi_pkg::AccW-1:0]    corrected_o,
  output logic [acdi_pkg::MaxAxes-1:0][acdi_pkg::StateW-1:0]  position_o
);

  localparam int AccW   = acdi_pkg::AccW;
  localparam int GainW  = acdi_pkg::GainW;
  localparam int StepW  = acdi_pkg::StepW;
  localparam int StateW = acdi_pkg::StateW;
  localparam int Half   = StateW / 2;
  localparam int MulAW  = AccW + 1;
  localparam int MulBW  = GainW + 1;
  localparam int ProdW  = MulAW + MulBW;
  localparam int PartW  = Half + StepW;
  localparam int HiPW   = Half + StepW + 1;
  localparam int FullW  = HiPW + Half + 1;

  localparam logic [AccW-1:0]   AccMax   = {1'b0, {(AccW-1){1'b1}}};
  localparam logic [AccW-1:0]   AccMin   = {1'b1, {(AccW-1){1'b0}}};
  localparam logic [StateW-1:0] StateMax = {1'b0, {(StateW-1){1'b1}}};
  localparam logic [StateW-1:0] StateMin = {1'b1, {(StateW-1){1'b0}}};

  for (genvar a = 0; a < acdi_pkg::MaxAxes; a++) begin : g_lane
    if (a < NUM_AXES) begin : g_on
      logic signed [MulAW-1:0]  diff_q;
      logic signed [ProdW-1:0]  prod_q;
      logic        [PartW-1:0]  part_q;
      logic        [AccW-1:0]   corr_q;
      logic        [StateW-1:0] vel_q;
      logic        [StateW-1:0] pos_q;
      logic        [AccW-1:0]   out_corr_q;
      logic        [StateW-1:0] out_pos_q;

      logic signed [MulAW-1:0]  mul_a;
      logic signed [MulBW-1:0]  mul_b;
      logic signed [ProdW-1:0]  mult;
      logic signed [ProdW-1:0]  prod_sh;
      logic        [AccW-1:0]   corr_sat;
      logic signed [ProdW:0]    vsum;
      logic        [StateW-1:0] vel_sat;
      logic        [HiPW-1:0]   hi_prod;
      logic signed [FullW-1:0]  full;
      logic signed [FullW-1:0]  full_sh;
      logic signed [FullW:0]    psum;
      logic        [StateW-1:0] pos_sat;

      // Pick multiplier operands for the current step
      always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (op_i)
          acdi_pkg::OP_MUL_GAIN: begin
            mul_a = diff_q;
            mul_b = $signed({gain_i[a][GainW-1], gain_i[a]});
          end
          acdi_pkg::OP_MUL_CORR: begin
            mul_a = $signed({corr_q[AccW-1], corr_q});
            mul_b = $signed({{(MulBW-StepW){1'b0}}, step_i});
          end
          acdi_pkg::OP_MUL_VLO: begin
            mul_a = $signed({{(MulAW-Half){1'b0}}, vel_q[Half-1:0]});
            mul_b = $signed({{(MulBW-StepW){1'b0}}, step_i});
          end
          acdi_pkg::OP_MUL_VHI: begin
            mul_a = $signed({{(MulAW-Half){vel_q[StateW-1]}}, vel_q[StateW-1:Half]});
            mul_b = $signed({{(MulBW-StepW){1'b0}}, step_i});
          end
          default: ;
        endcase
        mult = mul_a * mul_b;
      end

      // Floor-shift the product, then saturate for each accumulate step
      always_comb begin
        prod_sh = prod_q >>> FRAC_BITS;

        if (&prod_sh[ProdW-1:AccW-1] || ~|prod_sh[ProdW-1:AccW-1]) begin
          corr_sat = prod_sh[AccW-1:0];
        end else begin
          corr_sat = prod_sh[ProdW-1] ? AccMin : AccMax;
        end

        vsum = $signed({{(ProdW+1-StateW){vel_q[StateW-1]}}, vel_q})
             + $signed({prod_sh[ProdW-1], prod_sh});
        if (&vsum[ProdW:StateW-1] || ~|vsum[ProdW:StateW-1]) begin
          vel_sat = vsum[StateW-1:0];
        end else begin
          vel_sat = vsum[ProdW] ? StateMin : StateMax;
        end

        // Recombine the two halves of velocity times step
        hi_prod = prod_q[HiPW-1:0];
        full    = $signed({{(FullW-HiPW-Half){hi_prod[HiPW-1]}}, hi_prod, {Half{1'b0}}})
                + $signed({{(FullW-PartW){1'b0}}, part_q});
        full_sh = full >>> FRAC_BITS;
        psum    = $signed({{(FullW+1-StateW){pos_q[StateW-1]}}, pos_q})
                + $signed({full_sh[FullW-1], full_sh});
        if (&psum[FullW:StateW-1] || ~|psum[FullW:StateW-1]) begin
          pos_sat = psum[StateW-1:0];
        end else begin
          pos_sat = psum[FullW] ? StateMin : StateMax;
        end
      end

      // Working registers of the lane
      always_ff @(posedge clk_i) begin
        case (op_i)
          acdi_pkg::OP_LOAD: begin
            diff_q <= $signed({accel_i[a][AccW-1], accel_i[a]})
                    - $signed({bias_i[a][AccW-1], bias_i[a]});
          end
          acdi_pkg::OP_MUL_GAIN, acdi_pkg::OP_MUL_CORR, acdi_pkg::OP_MUL_VLO: begin
            prod_q <= mult;
          end
          acdi_pkg::OP_MUL_VHI: begin
            part_q <= prod_q[PartW-1:0];
            prod_q <= mult;
          end
          acdi_pkg::OP_CORR: corr_q <= corr_sat;
          acdi_pkg::OP_POS: begin
            out_corr_q <= corr_q;
            out_pos_q  <= pos_sat;
          end
          default: ;
        endcase
      end

      // Kept velocity and position
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vel_q <= '0;
          pos_q <= '0;
        end else begin
          case (op_i)
            acdi_pkg::OP_VEL: vel_q <= vel_sat;
            acdi_pkg::OP_POS: pos_q <= pos_sat;
            default: ;
          endcase
        end
      end

      assign corrected_o[a] = out_corr_q;
      assign position_o[a]  = out_pos_q;
    end else begin : g_off
      assign corrected_o[a] = '0;
      assign position_o[a]  = '0;
    end
  end

endmodule

### rtl/acdi_ctrl.sv
module acdi_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output acdi_pkg::op_e op_o
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_MUL_GAIN = 3'd1;
  localparam logic [2:0] ST_CORR     = 3'd2;
  localparam logic [2:0] ST_MUL_CORR = 3'd3;
  localparam logic [2:0] ST_VEL      = 3'd4;
  localparam logic [2:0] ST_MUL_VLO  = 3'd5;
  localparam logic [2:0] ST_MUL_VHI  = 3'd6;
  localparam logic [2:0] ST_POS      = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // Step sequence; the last step waits for a free output slot
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    op_o        = acdi_pkg::OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_o    = acdi_pkg::OP_LOAD;
          state_d = ST_MUL_GAIN;
        end
      end
      ST_MUL_GAIN: begin
        op_o    = acdi_pkg::OP_MUL_GAIN;
        state_d = ST_CORR;
      end
      ST_CORR: begin
        op_o    = acdi_pkg::OP_CORR;
        state_d = ST_MUL_CORR;
      end
      ST_MUL_CORR: begin
        op_o    = acdi_pkg::OP_MUL_CORR;
        state_d = ST_VEL;
      end
      ST_VEL: begin
        op_o    = acdi_pkg::OP_VEL;
        state_d = ST_MUL_VLO;
      end
      ST_MUL_VLO: begin
        op_o    = acdi_pkg::OP_MUL_VLO;
        state_d = ST_MUL_VHI;
      end
      ST_MUL_VHI: begin
        op_o    = acdi_pkg::OP_MUL_VHI;
        state_d = ST_POS;
      end
      ST_POS: begin
        if (out_free) begin
          op_o        = acdi_pkg::OP_POS;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### rtl/accel_correct_double_integrator_core.sv
// Each accepted input beat runs through an eight-step sequence that each axis
//   lane runs through its single 33x25 multiplier; the result beat is registered
//   in the last step, which waits while a previous result is stalled, and no new
//   input beat is taken until the sequence is done.
// Reset: rst_ni is asynchronous and active low; it clears velocity and position
//   to zero and returns the configuration registers to their defaults.
module accel_correct_double_integrator_core #(
  parameter int NUM_AXES  = acdi_pkg::NumAxesDef,
  parameter int FRAC_BITS = acdi_pkg::FracBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [acdi_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [acdi_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [acdi_pkg::AccW-1:0]     accel_x_i,
  input  logic signed [acdi_pkg::AccW-1:0]     accel_y_i,
  input  logic signed [acdi_pkg::AccW-1:0]     accel_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [acdi_pkg::AccW-1:0]     corrected_x_o,
  output logic signed [acdi_pkg::AccW-1:0]     corrected_y_o,
  output logic signed [acdi_pkg::AccW-1:0]     corrected_z_o,
  output logic signed [acdi_pkg::StateW-1:0]   position_x_o,
  output logic signed [acdi_pkg::StateW-1:0]   position_y_o,
  output logic signed [acdi_pkg::StateW-1:0]   position_z_o
);

  logic [acdi_pkg::MaxAxes-1:0][acdi_pkg::AccW-1:0]   accel;
  logic [acdi_pkg::MaxAxes-1:0][acdi_pkg::AccW-1:0]   bias;
  logic [acdi_pkg::MaxAxes-1:0][acdi_pkg::GainW-1:0]  gain;
  logic [acdi_pkg::StepW-1:0]                         step;
  logic [acdi_pkg::MaxAxes-1:0][acdi_pkg::AccW-1:0]   corrected;
  logic [acdi_pkg::MaxAxes-1:0][acdi_pkg::StateW-1:0] position;
  acdi_pkg::op_e                                      op;

  assign accel[0] = accel_x_i;
  assign accel[1] = accel_y_i;
  assign accel[2] = accel_z_i;

  acdi_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .bias_o     (bias),
    .gain_o     (gain),
    .step_o     (step)
  );

  acdi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .op_o        (op)
  );

  acdi_dp #(
    .NUM_AXES  (NUM_AXES),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .accel_i     (accel),
    .bias_i      (bias),
    .gain_i      (gain),
    .step_i      (step),
    .corrected_o (corrected),
    .position_o  (position)
  );

  assign corrected_x_o = corrected[0];
  assign corrected_y_o = corrected[1];
  assign corrected_z_o = corrected[2];
  assign position_x_o  = position[0];
  assign position_y_o  = position[1];
  assign position_z_o  = position[2];

endmodule

### rtl/acdi_checker.sv
module acdi_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic signed [acdi_pkg::AccW-1:0]     corrected_x_o,
  input logic signed [acdi_pkg::AccW-1:0]     corrected_y_o,
  input logic signed [acdi_pkg::AccW-1:0]     corrected_z_o,
  input logic signed [acdi_pkg::StateW-1:0]   position_x_o,
  input logic signed [acdi_pkg::StateW-1:0]   position_y_o,
  input logic signed [acdi_pkg::StateW-1:0]   position_z_o
);

  logic in_beat;
  assign in_beat = in_valid_i && !in_stall_o;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // Keep a stalled result payload steady
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(corrected_x_o) && $stable(corrected_y_o)
      && $stable(corrected_z_o) && $stable(position_x_o) && $stable(position_y_o)
      && $stable(position_z_o))
    else $error("stalled result payload changed");

  // Stay busy right after an input beat and again at the final step of the sequence
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> in_stall_o ##6 in_stall_o)
    else $error("input taken before the step sequence finished");

  // Raise a new result only out of a busy step
  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result beat raised without a busy step before it");

endmodule

bind accel_correct_double_integrator_core acdi_checker u_acdi_checker (.*);

### sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CfgIdxW  = acdi_pkg::CfgIdxW;
  localparam int CfgDataW = acdi_pkg::CfgDataW;
  localparam int AccW     = acdi_pkg::AccW;
  localparam int GainW    = acdi_pkg::GainW;
  localparam int StepW    = acdi_pkg::StepW;
  localparam int StateW   = acdi_pkg::StateW;

  // Register index with no register behind it
  localparam logic [CfgIdxW-1:0] RegUnmapped = 3'd7;

  localparam logic signed [AccW-1:0]   AccMax  = 32'sh7FFF_FFFF;
  localparam logic signed [AccW-1:0]   AccMin  = 32'sh8000_0000;
  localparam logic signed [GainW-1:0]  GainMax = 24'sh7F_FFFF;
  localparam logic signed [GainW-1:0]  GainMin = 24'sh80_0000;
  localparam logic signed [GainW-1:0]  GainOne = acdi_pkg::GainReset;
  localparam logic [StepW-1:0]         StepMax = 16'hFFFF;
  localparam logic signed [StateW-1:0] PosMax  = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [StateW-1:0] PosMin  = 48'sh8000_0000_0000;

  localparam int StallMax   = 12;
  localparam int SettleWait = 16;
  localparam int IdleLimit  = 2000;

  typedef logic signed [95:0] wide_t;

  typedef struct packed {
    logic [2:0][AccW-1:0]   corr;
    logic [2:0][StateW-1:0] pos;
  } nav_beat_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CfgIdxW-1:0]       cfg_idx_i;
  logic [CfgDataW-1:0]      cfg_data_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic signed [AccW-1:0]   accel_x_i;
  logic signed [AccW-1:0]   accel_y_i;
  logic signed [AccW-1:0]   accel_z_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [AccW-1:0]   corrected_x_o;
  logic signed [AccW-1:0]   corrected_y_o;
  logic signed [AccW-1:0]   corrected_z_o;
  logic signed [StateW-1:0] position_x_o;
  logic signed [StateW-1:0] position_y_o;
  logic signed [StateW-1:0] position_z_o;

  // Shadow copy of the configuration and the integrator state
  logic signed [AccW-1:0]   shadow_bias [3];
  logic signed [GainW-1:0]  shadow_gain [3];
  logic [StepW-1:0]         shadow_step;
  logic signed [StateW-1:0] track_vel [3];
  logic signed [StateW-1:0] track_pos [3];

  nav_beat_t nav_expect_q [$];
  nav_beat_t got_beat;
  int        errors;
  int        stall_left;
  int        idle_cycles;
  bit        send_gaps;
  bit        recv_stalls;

  accel_correct_double_integrator_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .accel_x_i     (accel_x_i),
    .accel_y_i     (accel_y_i),
    .accel_z_i     (accel_z_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .corrected_x_o (corrected_x_o),
    .corrected_y_o (corrected_y_o),
    .corrected_z_o (corrected_z_o),
    .position_x_o  (position_x_o),
    .position_y_o  (position_y_o),
    .position_z_o  (position_z_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Clamp a wide signed value to a w-bit signed range
  function automatic wide_t clamp_to(input wide_t v, input int w);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (w - 1)) - wide_t'(1);
    lo = -hi - wide_t'(1);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Correct one sample, advance velocity and position, return the beat due
  function automatic nav_beat_t integrate_sample(input logic signed [AccW-1:0] ax, ay, az);
    logic signed [AccW-1:0] raw [3];
    wide_t dt_w;
    wide_t diff;
    wide_t corr_w;
    wide_t vel_w;
    wide_t pos_w;
    nav_beat_t beat;
    raw[0] = ax;
    raw[1] = ay;
    raw[2] = az;
    dt_w = {80'd0, shadow_step};
    for (int a = 0; a < 3; a++) begin
      diff   = wide_t'(raw[a]) - wide_t'(shadow_bias[a]);
      corr_w = clamp_to((diff * wide_t'(shadow_gain[a])) >>> acdi_pkg::FracBitsDef, AccW);
      vel_w  = clamp_to(wide_t'(track_vel[a])
                        + ((corr_w * dt_w) >>> acdi_pkg::FracBitsDef), StateW);
      pos_w  = clamp_to(wide_t'(track_pos[a])
                        + ((vel_w * dt_w) >>> acdi_pkg::FracBitsDef), StateW);
      track_vel[a]  = vel_w[StateW-1:0];
      track_pos[a]  = pos_w[StateW-1:0];
      beat.corr[a]  = corr_w[AccW-1:0];
      beat.pos[a]   = pos_w[StateW-1:0];
    end
    return beat;
  endfunction

  // Random acceleration: full range, near zero, or an extreme
  function automatic logic signed [AccW-1:0] rand_accel();
    case ($urandom_range(0, 3))
      0: return AccW'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      1: begin
        case ($urandom_range(0, 3))
          0: return AccMax;
          1: return AccMin;
          2: return -32'sd1;
          default: return 32'sd0;
        endcase
      end
      default: return AccW'($urandom);
    endcase
  endfunction

  // Drive one register write; the caller lowers the write enable
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      acdi_pkg::RegBiasX: shadow_bias[0] = data;
      acdi_pkg::RegBiasY: shadow_bias[1] = data;
      acdi_pkg::RegBiasZ: shadow_bias[2] = data;
      acdi_pkg::RegGainX: shadow_gain[0] = data[GainW-1:0];
      acdi_pkg::RegGainY: shadow_gain[1] = data[GainW-1:0];
      acdi_pkg::RegGainZ: shadow_gain[2] = data[GainW-1:0];
      acdi_pkg::RegStep:  shadow_step    = data[StepW-1:0];
      default: ;
    endcase
  endtask

  // Write all registers; junk in the unused upper bits must be dropped
  task automatic program_regs(input logic [AccW-1:0] bx, by, bz,
                              input logic [GainW-1:0] gx, gy, gz,
                              input logic [StepW-1:0] st);
    write_reg(acdi_pkg::RegBiasX, bx);
    write_reg(acdi_pkg::RegBiasY, by);
    write_reg(acdi_pkg::RegBiasZ, bz);
    write_reg(acdi_pkg::RegGainX, {8'($urandom), gx});
    write_reg(acdi_pkg::RegGainY, {8'($urandom), gy});
    write_reg(acdi_pkg::RegGainZ, {8'($urandom), gz});
    write_reg(acdi_pkg::RegStep, {16'($urandom), st});
    cfg_we_i <= 1'b0;
  endtask

  // Send one sample beat after a random gap and record its expected result
  task automatic send_sample(input logic signed [AccW-1:0] ax, ay, az);
    int gap;
    gap = send_gaps ? $urandom_range(0, StallMax) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    accel_x_i  <= ax;
    accel_y_i  <= ay;
    accel_z_i  <= az;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    nav_expect_q.push_back(integrate_sample(ax, ay, az));
  endtask

  // Hold off the sender until every result is back, then let the pipe empty
  task automatic drain();
    in_valid_i <= 1'b0;
    while (nav_expect_q.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  task automatic test_default_regs();
    send_gaps   = 1'b0;
    recv_stalls = 1'b0;
    send_sample(32'sd0, 32'sd0, 32'sd0);
    send_sample(AccMax, AccMin, -32'sd1);
    send_sample(AccMin, AccMax, 32'sd1);
    send_sample(32'sd1, -32'sd1, 32'sh0001_0000);
    send_sample(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh7FFF_0000);
    drain();
  endtask

  // Drive the corrected acceleration into both clamps
  task automatic test_correction_clamp();
    send_gaps   = 1'b1;
    recv_stalls = 1'b1;
    program_regs(AccMin, AccMax, 32'sd0, GainMax, GainMax, GainMin, acdi_pkg::StepReset);
    send_sample(AccMax, AccMin, AccMax);
    send_sample(AccMin, AccMax, AccMin);
    send_sample(32'sd0, 32'sd0, 32'sd0);
    drain();
    program_regs(-32'sd1, 32'sd1, AccMin, GainMin, 24'sd0, -24'sd1, StepMax);
    send_sample(AccMax, AccMin, AccMax);
    send_sample(AccMin, AccMax, -32'sd1);
    drain();
  endtask

  // With a zero step velocity and position hold
  task automatic test_zero_step();
    program_regs(32'sd0, 32'sd0, 32'sd0, GainOne, GainOne, GainOne, 16'd0);
    send_sample(AccMax, AccMin, 32'sh0003_0000);
    send_sample(AccMin, AccMax, -32'sh0003_0000);
    send_sample(rand_accel(), rand_accel(), rand_accel());
    drain();
  endtask

  // A write to the unmapped index must change nothing
  task automatic test_unmapped_index();
    program_regs(32'sh0001_0000, -32'sh0002_0000, 32'sh1234_5678,
                 GainOne, 24'sh00_8000, 24'shFF_0000, acdi_pkg::StepReset);
    @(posedge clk_i);
    write_reg(RegUnmapped, 32'hFFFF_FFFF);
    cfg_we_i <= 1'b0;
    send_sample(32'sh0004_0000, 32'sh0004_0000, 32'sh0004_0000);
    send_sample(-32'sh0001_0000, AccMax, AccMin);
    drain();
  endtask

  // Random configurations, each followed by a burst of random samples
  task automatic test_random_phases();
    logic [AccW-1:0]  bias [3];
    logic [GainW-1:0] gain [3];
    logic [StepW-1:0] st;
    for (int ph = 0; ph < 6; ph++) begin
      send_gaps   = (ph == 2) ? 1'b0 : 1'($urandom);
      recv_stalls = (ph == 2) ? 1'b0 : 1'($urandom);
      for (int a = 0; a < 3; a++) begin
        bias[a] = $urandom_range(0, 1) ? AccW'($urandom) : rand_accel();
        case ($urandom_range(0, 2))
          0: gain[a] = GainW'($urandom);
          1: gain[a] = GainOne + GainW'($urandom_range(0, 16'hFFFF)) - 24'sh00_8000;
          default: gain[a] = GainW'($urandom_range(0, 24'h02_0000)) - 24'sh01_0000;
        endcase
      end
      case ($urandom_range(0, 3))
        0: st = StepMax;
        1: st = acdi_pkg::StepReset;
        2: st = StepW'($urandom_range(0, 4096));
        default: st = StepW'($urandom);
      endcase
      program_regs(bias[0], bias[1], bias[2], gain[0], gain[1], gain[2], st);
      for (int n = 0; n < 50; n++) send_sample(rand_accel(), rand_accel(), rand_accel());
      drain();
    end
  endtask

  // Push x position to the top clamp and y to the bottom, then hold them
  task automatic test_position_clamp();
    int n;
    int tail;
    logic [AccW-1:0] bz;
    send_gaps   = 1'b1;
    recv_stalls = 1'b1;
    bz = $urandom;
    program_regs(32'sd0, 32'sd0, bz, GainMax, GainMax, GainOne, StepMax);
    n    = 0;
    tail = 0;
    while (n < 800 && tail < 8) begin
      if (n == 100) send_gaps = 1'b0;
      send_sample(AccW'($urandom_range(32'h0100_0000, 32'h7FFF_FFFF)),
                  -AccW'($urandom_range(32'h0100_0000, 32'h7FFF_FFFF)),
                  rand_accel());
      n++;
      if (track_pos[0] == PosMax && track_pos[1] == PosMin) tail++;
    end
    drain();
    // Clamped state must hold with a zero step as well
    program_regs(32'sd0, 32'sd0, bz, GainMax, GainMax, GainOne, 16'd0);
    send_sample(AccMin, AccMax, rand_accel());
    send_sample(rand_accel(), rand_accel(), rand_accel());
    drain();
  endtask

  task automatic check_field(input string name, input logic signed [StateW-1:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Check each result beat and draw the stall before the next one
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (nav_expect_q.size() == 0) begin
        $error("result beat with no sample pending");
        errors++;
      end else begin
        got_beat = nav_expect_q.pop_front();
        check_field("corrected_x", $signed(got_beat.corr[0]), corrected_x_o);
        check_field("corrected_y", $signed(got_beat.corr[1]), corrected_y_o);
        check_field("corrected_z", $signed(got_beat.corr[2]), corrected_z_o);
        check_field("position_x", $signed(got_beat.pos[0]), position_x_o);
        check_field("position_y", $signed(got_beat.pos[1]), position_y_o);
        check_field("position_z", $signed(got_beat.pos[2]), position_z_o);
      end
      stall_left = recv_stalls ? $urandom_range(0, StallMax) : 0;
    end else if (stall_left != 0) begin
      stall_left--;
    end
    out_stall_i <= (stall_left != 0);
  end

  // Abort when no beat moves on either side for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    accel_x_i   = '0;
    accel_y_i   = '0;
    accel_z_i   = '0;
    out_stall_i = 1'b0;
    errors      = 0;
    stall_left  = 0;
    idle_cycles = 0;
    send_gaps   = 1'b0;
    recv_stalls = 1'b0;
    for (int a = 0; a < 3; a++) begin
      shadow_bias[a] = acdi_pkg::BiasReset;
      shadow_gain[a] = acdi_pkg::GainReset;
      track_vel[a]   = '0;
      track_pos[a]   = '0;
    end
    shadow_step = acdi_pkg::StepReset;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_regs();
    test_correction_clamp();
    test_zero_step();
    test_unmapped_index();
    test_random_phases();
    test_position_clamp();

    if (errors == 0 && nav_expect_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/acdi_pkg.sv
rtl/acdi_cfg.sv
rtl/acdi_dp.sv
rtl/acdi_ctrl.sv
rtl/accel_correct_double_integrator_core.sv
rtl/acdi_checker.sv
sim/testbench.sv
